// ===== src/gpv_pkg.sv =====
`default_nettype none

package gpv_pkg;

	localparam int HEIGHT_BITS    = 16;
	localparam int POS_BITS       = 10;
	localparam int CNT_BITS       = 20;
	localparam int CFG_BITS       = 11;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_RESET      = 12;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS = 2'd1;

	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_PEAK   = 2'd1;
	localparam logic [1:0] CLS_VALLEY = 2'd2;

	typedef struct packed {
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic                emit;
		logic                last;
	} gpv_meta_t;

endpackage

`default_nettype wire

// ===== src/gpv_line_buf.sv =====
`default_nettype none

module gpv_line_buf #(
	parameter int MAX_WIDTH   = gpv_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = gpv_pkg::DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = gpv_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [gpv_pkg::HEIGHT_BITS-1:0]  height,
	input  wire logic                                    cfg_wr,
	input  wire logic                                    cfg_clr,
	input  wire logic        [gpv_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  wire logic        [gpv_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire logic                                    rdy_s2,
	output logic                                         v_s1,
	output gpv_pkg::gpv_meta_t                           meta_s1,
	output logic signed      [SAMPLE_BITS-1:0]           top_s1,
	output logic signed      [SAMPLE_BITS-1:0]           mid_s1,
	output logic signed      [SAMPLE_BITS-1:0]           bot_s1
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);
	localparam int RST_ROWS = ((gpv_pkg::CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
		gpv_pkg::CFG_RESET) - 1;
	localparam int RST_COLS = ((gpv_pkg::CFG_RESET > MAX_WIDTH) ? MAX_WIDTH :
		gpv_pkg::CFG_RESET) - 1;

	logic signed [SAMPLE_BITS-1:0] mem_a [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] mem_b [MAX_WIDTH];

	logic [RB-1:0] rows_m1_q;
	logic [CB-1:0] cols_m1_q;
	logic [RB-1:0] row_q;
	logic [CB-1:0] col_q;
	logic [CB-1:0] addr_s1;

	logic                          rdy_s1;
	logic                          acc;
	logic                          adv_s1;
	logic                          col_end;
	logic                          last;
	logic signed [SAMPLE_BITS-1:0] smp;

	function automatic logic [31:0] dim_m1(input logic [gpv_pkg::CFG_BITS-1:0] v,
		input int unsigned maxv);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0)
			return 32'd0;
		if (w > maxv)
			return maxv - 32'd1;
		return w - 32'd1;
	endfunction

	generate
		if (SAMPLE_BITS <= gpv_pkg::HEIGHT_BITS) begin : g_narrow
			assign smp = height[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign smp = {{(SAMPLE_BITS - gpv_pkg::HEIGHT_BITS){1'b0}}, height};
		end
	endgenerate

	assign rdy_s1   = !v_s1 || rdy_s2;
	assign acc      = in_valid && rdy_s1;
	assign adv_s1   = v_s1 && rdy_s2;
	assign in_stall = !rdy_s1;
	assign col_end  = (col_q == cols_m1_q);
	assign last     = (row_q == rows_m1_q) && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= RB'(RST_ROWS);
			cols_m1_q <= CB'(RST_COLS);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				gpv_pkg::REG_NUM_ROWS: rows_m1_q <= RB'(dim_m1(cfg_data, MAX_HEIGHT));
				gpv_pkg::REG_NUM_COLS: cols_m1_q <= CB'(dim_m1(cfg_data, MAX_WIDTH));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_clr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_end) begin
				row_q <= row_q + RB'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + CB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1.row  <= gpv_pkg::POS_BITS'(32'(row_q) - 32'd1);
			meta_s1.col  <= gpv_pkg::POS_BITS'(32'(col_q) - 32'd1);
			meta_s1.emit <= (row_q >= RB'(2)) && (col_q >= CB'(2));
			meta_s1.last <= last;
			bot_s1       <= smp;
			addr_s1      <= col_q;
		end
	end

	// old row moves down into the second store as the item leaves stage one
	always_ff @(posedge clk) begin
		if (acc) begin
			top_s1       <= mem_b[col_q];
			mid_s1       <= mem_a[col_q];
			mem_a[col_q] <= smp;
		end
		if (adv_s1)
			mem_b[addr_s1] <= mid_s1;
	end

endmodule

`default_nettype wire

// ===== src/gpv_window.sv =====
`default_nettype none

module gpv_window #(
	parameter int SAMPLE_BITS = gpv_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          v_s1,
	input  wire gpv_pkg::gpv_meta_t            meta_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] top_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] mid_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] bot_s1,
	input  wire logic                          rdy_s4,
	output logic                               rdy_s2,
	output logic                               v_s3,
	output gpv_pkg::gpv_meta_t                 meta_s3,
	output logic             [1:0]             cls_s3
);

	logic signed [SAMPLE_BITS-1:0] win_s2 [3][3];
	logic                          v_s2;
	gpv_pkg::gpv_meta_t            meta_s2;

	logic       rdy_s3;
	logic       adv_s2;
	logic       adv_s3;
	logic       peak;
	logic       valley;
	logic [1:0] cls;

	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign adv_s2 = v_s1 && rdy_s2;
	assign adv_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	// shift the window left and take the new column
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int r = 0; r < 3; r++) begin
				win_s2[r][0] <= win_s2[r][1];
				win_s2[r][1] <= win_s2[r][2];
			end
			win_s2[0][2] <= top_s1;
			win_s2[1][2] <= mid_s1;
			win_s2[2][2] <= bot_s1;
			meta_s2      <= meta_s1;
		end
	end

	always_comb begin
		peak   = 1'b1;
		valley = 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (r != 1 || c != 1) begin
					if (!(win_s2[r][c] < win_s2[1][1]))
						peak = 1'b0;
					if (!(win_s2[r][c] > win_s2[1][1]))
						valley = 1'b0;
				end
			end
		end
		if (peak)
			cls = gpv_pkg::CLS_PEAK;
		else if (valley)
			cls = gpv_pkg::CLS_VALLEY;
		else
			cls = gpv_pkg::CLS_NONE;
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			cls_s3  <= cls;
			meta_s3 <= meta_s2;
		end
	end

endmodule

`default_nettype wire

// ===== src/gpv_stats.sv =====
`default_nettype none

module gpv_stats (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             v_s3,
	input  wire gpv_pkg::gpv_meta_t               meta_s3,
	input  wire logic [1:0]                       cls_s3,
	input  wire logic                             cfg_clr,
	input  wire logic                             out_stall,
	output logic                                  rdy_s4,
	output logic                                  out_valid,
	output logic      [gpv_pkg::POS_BITS-1:0]     cell_row,
	output logic      [gpv_pkg::POS_BITS-1:0]     cell_col,
	output logic      [1:0]                       cell_class,
	output logic      [gpv_pkg::CNT_BITS-1:0]     peak_total,
	output logic      [gpv_pkg::CNT_BITS-1:0]     valley_total,
	output logic                                  frame_done
);

	logic [gpv_pkg::CNT_BITS-1:0] peak_q;
	logic [gpv_pkg::CNT_BITS-1:0] valley_q;
	logic [gpv_pkg::CNT_BITS-1:0] peak_nx;
	logic [gpv_pkg::CNT_BITS-1:0] valley_nx;
	logic                         adv;

	assign rdy_s4 = !out_valid || !out_stall;
	assign adv    = v_s3 && rdy_s4;

	// saturate at all ones
	assign peak_nx = (meta_s3.emit && cls_s3 == gpv_pkg::CLS_PEAK && peak_q != '1) ?
		peak_q + gpv_pkg::CNT_BITS'(1) : peak_q;
	assign valley_nx = (meta_s3.emit && cls_s3 == gpv_pkg::CLS_VALLEY && valley_q != '1) ?
		valley_q + gpv_pkg::CNT_BITS'(1) : valley_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			valley_q <= '0;
		end else if (cfg_clr) begin
			peak_q   <= '0;
			valley_q <= '0;
		end else if (adv) begin
			if (meta_s3.last) begin
				peak_q   <= '0;
				valley_q <= '0;
			end else begin
				peak_q   <= peak_nx;
				valley_q <= valley_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (rdy_s4)
			out_valid <= v_s3 && meta_s3.emit;
	end

	always_ff @(posedge clk) begin
		if (adv && meta_s3.emit) begin
			cell_row     <= meta_s3.row;
			cell_col     <= meta_s3.col;
			cell_class   <= cls_s3;
			peak_total   <= peak_nx;
			valley_total <= valley_nx;
			frame_done   <= meta_s3.last;
		end
	end

endmodule

`default_nettype wire

// ===== src/grid_peak_valley_detector_core.sv =====
// Streaming 3x3 peak and valley detector for a height grid.
// Input channel: one signed height sample per beat, raster order, taken at an
// edge with in_valid high and in_stall low. Output channel: one beat per
// interior cell (cell_row, cell_col, cell_class, running peak and valley
// totals, frame_done on the last interior cell), taken with out_valid high
// and out_stall low. Border samples produce no output beat.
// The sample completing a cell's window passes the line buffer, window, class
// and output registers. Throughput: one sample per cycle while the output is
// not stalled, set by the single read and write port of each line store.
// Configuration: wr_en writes wr_data into register wr_index (0 rows,
// 1 columns) and restarts the frame; write only while the pipeline is empty.
// Reset: 12 by 12 frame, position and totals cleared, pipeline empty. Line
// store contents are not cleared; a cell is only classified from samples of
// the current frame.
// A stall on the output holds the output beat; stages behind it keep filling
// bubbles and then stall the input, so nothing is dropped or repeated.
`default_nettype none

module grid_peak_valley_detector_core #(
	parameter int MAX_WIDTH   = gpv_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = gpv_pkg::DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = gpv_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [gpv_pkg::HEIGHT_BITS-1:0]  height,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic             [gpv_pkg::POS_BITS-1:0]     cell_row,
	output logic             [gpv_pkg::POS_BITS-1:0]     cell_col,
	output logic             [1:0]                       cell_class,
	output logic             [gpv_pkg::CNT_BITS-1:0]     peak_total,
	output logic             [gpv_pkg::CNT_BITS-1:0]     valley_total,
	output logic                                         frame_done,
	input  wire logic                                    wr_en,
	input  wire logic        [gpv_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  wire logic        [gpv_pkg::CFG_BITS-1:0]     wr_data
);

	logic                          cfg_clr;
	logic                          rdy_s2;
	logic                          rdy_s4;
	logic                          v_s1;
	logic                          v_s3;
	gpv_pkg::gpv_meta_t            meta_s1;
	gpv_pkg::gpv_meta_t            meta_s3;
	logic signed [SAMPLE_BITS-1:0] top_s1;
	logic signed [SAMPLE_BITS-1:0] mid_s1;
	logic signed [SAMPLE_BITS-1:0] bot_s1;
	logic        [1:0]             cls_s3;

	assign cfg_clr = wr_en && (wr_index == gpv_pkg::REG_NUM_ROWS ||
		wr_index == gpv_pkg::REG_NUM_COLS);

	gpv_line_buf #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.height   (height),
		.cfg_wr   (wr_en),
		.cfg_clr  (cfg_clr),
		.cfg_idx  (wr_index),
		.cfg_data (wr_data),
		.rdy_s2   (rdy_s2),
		.v_s1     (v_s1),
		.meta_s1  (meta_s1),
		.top_s1   (top_s1),
		.mid_s1   (mid_s1),
		.bot_s1   (bot_s1)
	);

	gpv_window #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.meta_s1 (meta_s1),
		.top_s1  (top_s1),
		.mid_s1  (mid_s1),
		.bot_s1  (bot_s1),
		.rdy_s4  (rdy_s4),
		.rdy_s2  (rdy_s2),
		.v_s3    (v_s3),
		.meta_s3 (meta_s3),
		.cls_s3  (cls_s3)
	);

	gpv_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s3         (v_s3),
		.meta_s3      (meta_s3),
		.cls_s3       (cls_s3),
		.cfg_clr      (cfg_clr),
		.out_stall    (out_stall),
		.rdy_s4       (rdy_s4),
		.out_valid    (out_valid),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.cell_class   (cell_class),
		.peak_total   (peak_total),
		.valley_total (valley_total),
		.frame_done   (frame_done)
	);

endmodule

`default_nettype wire
